// File: rtl/xcc_pkg.sv
// Shared types, constants and the xorshift32 step function for the pixel cipher.
// No dependencies.
package xcc_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned PIX_W    = 24;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SKIP_W   = 24;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned SHIFT_A = 13;
  localparam int unsigned SHIFT_B = 17;
  localparam int unsigned SHIFT_C = 5;

  localparam logic [WORD_W-1:0] RESET_SEED = WORD_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED         = CFG_IDX_W'(0),
    REG_START_VALUE  = CFG_IDX_W'(1),
    REG_SKIP_COUNT   = CFG_IDX_W'(2),
    REG_DECRYPT_MODE = CFG_IDX_W'(3)
  } cfg_reg_e;

  typedef struct packed {
    logic load;
    logic step;
  } gen_ctrl_t;

  function automatic logic [WORD_W-1:0] advance(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x ^ (x << SHIFT_A);
    y = y ^ (y >> SHIFT_B);
    y = y ^ (y << SHIFT_C);
    return y;
  endfunction

endpackage

// File: rtl/xcc_pix_in_if.sv
// Input pixel channel: valid/ready handshake with one 24-bit pixel and a first marker.
// Depends on nothing.
interface xcc_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;
  logic       first_pixel;

  modport source (output valid, output blue_in, output green_in, output red_in,
                  output first_pixel, input ready);
  modport sink (input valid, input blue_in, input green_in, input red_in,
                input first_pixel, output ready);
endinterface

// File: rtl/xcc_pix_out_if.sv
// Output pixel channel: valid/ready handshake with one transformed 24-bit pixel.
// Depends on nothing.
interface xcc_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;

  modport source (output valid, output blue_out, output green_out, output red_out,
                  input ready);
  modport sink (input valid, input blue_out, input green_out, input red_out,
                output ready);
endinterface

// File: rtl/xcc_gen.sv
// Shared xorshift32 stepping unit: generator state register with load and step.
// Depends on xcc_pkg.
module xcc_gen (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  xcc_pkg::gen_ctrl_t             ctrl_i,
  input  logic [xcc_pkg::WORD_W-1:0]     seed_i,
  output logic [xcc_pkg::WORD_W-1:0]     next_o
);

  logic [xcc_pkg::WORD_W-1:0] state_q;
  logic [xcc_pkg::WORD_W-1:0] state_d;

  assign next_o = xcc_pkg::advance(state_q);

  always_comb begin
    priority if (ctrl_i.load) begin
      state_d = seed_i;
    end else if (ctrl_i.step) begin
      state_d = next_o;
    end else begin
      state_d = state_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xcc_pkg::RESET_SEED;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/xorshift_chained_xor_pixel_cipher.sv
// Top level of the chained XOR pixel cipher with an xorshift32 keystream.
// Depends on xcc_pkg, xcc_pix_in_if, xcc_pix_out_if and xcc_gen.
//
// Usage:
//   in_i carries one pixel (blue, green, red) and a first_pixel marker per
//   transaction; out_o returns one transformed pixel per transaction.
//   cfg_we_i/cfg_idx_i/cfg_data_i write seed (0), start_value (1),
//   skip_count (2) and decrypt_mode (3); other indexes are dropped. All but
//   decrypt_mode take effect on the next first pixel; writes must be made
//   only while idle, which the block itself does not enforce.
// Sequencing:
//   A pixel is accepted only in S_IDLE. A first pixel reloads the generator
//   from the seed and steps it once per cycle skip_count times (S_SKIP) in
//   the single xorshift unit; each result is registered in S_STEP once the
//   output register is free, and only then is the next pixel accepted.
// Reset:
//   The generator holds 1, the chain pixel 0, all registers take their
//   defaults and no result is pending.
// Stall:
//   A finished result waits in the output register; the next pixel is still
//   accepted, and its result is held back until the receiver takes the first.
module xorshift_chained_xor_pixel_cipher (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [xcc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [xcc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  xcc_pix_in_if.sink                      in_i,
  xcc_pix_out_if.source                   out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SKIP,
    S_STEP
  } state_e;

  state_e                         state_q;
  logic [xcc_pkg::WORD_W-1:0]     seed_q;
  logic [xcc_pkg::WORD_W-1:0]     start_q;
  logic [xcc_pkg::SKIP_W-1:0]     skip_q;
  logic                           decrypt_q;

  logic [xcc_pkg::SKIP_W-1:0]     count_q;
  logic [xcc_pkg::PIX_W-1:0]      pix_q;
  logic [xcc_pkg::PIX_W-1:0]      chain_q;
  logic [xcc_pkg::PIX_W-1:0]      res_q;
  logic                           out_valid_q;

  xcc_pkg::gen_ctrl_t             gen_ctrl;
  logic [xcc_pkg::WORD_W-1:0]     gen_next;
  logic [xcc_pkg::PIX_W-1:0]      res;
  logic                           in_acc;
  logic                           out_free;
  logic                           emit;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign emit       = (state_q == S_STEP) && out_free;
  assign res        = pix_q ^ chain_q ^ gen_next[xcc_pkg::PIX_W-1:0];

  always_comb begin
    gen_ctrl.load = in_acc && in_i.first_pixel;
    gen_ctrl.step = (state_q == S_SKIP) || emit;
  end

  xcc_gen u_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (gen_ctrl),
    .seed_i (seed_q),
    .next_o (gen_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= xcc_pkg::RESET_SEED;
      start_q   <= '0;
      skip_q    <= '0;
      decrypt_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        xcc_pkg::REG_SEED:         seed_q    <= cfg_data_i;
        xcc_pkg::REG_START_VALUE:  start_q   <= cfg_data_i;
        xcc_pkg::REG_SKIP_COUNT:   skip_q    <= cfg_data_i[xcc_pkg::SKIP_W-1:0];
        xcc_pkg::REG_DECRYPT_MODE: decrypt_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      chain_q     <= '0;
      count_q     <= '0;
      pix_q       <= '0;
      res_q       <= '0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            pix_q <= {in_i.red_in, in_i.green_in, in_i.blue_in};
            if (in_i.first_pixel) begin
              chain_q <= start_q[xcc_pkg::PIX_W-1:0];
              count_q <= skip_q;
              state_q <= (skip_q != '0) ? S_SKIP : S_STEP;
            end else begin
              state_q <= S_STEP;
            end
          end
        end
        S_SKIP: begin
          count_q <= count_q - xcc_pkg::SKIP_W'(1);
          if (count_q == xcc_pkg::SKIP_W'(1)) begin
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          if (emit) begin
            res_q       <= res;
            out_valid_q <= 1'b1;
            chain_q     <= decrypt_q ? pix_q : res;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.blue_out  = res_q[xcc_pkg::BYTE_W-1:0];
  assign out_o.green_out = res_q[2*xcc_pkg::BYTE_W-1:xcc_pkg::BYTE_W];
  assign out_o.red_out   = res_q[3*xcc_pkg::BYTE_W-1:2*xcc_pkg::BYTE_W];

endmodule

// File: verif/testbench.sv
// Self-checking testbench for xorshift_chained_xor_pixel_cipher: drives pixel transactions
// with bursty valid and a stalling receiver, and checks each result against a scoreboard.
// Depends on xcc_pkg, xcc_pix_in_if, xcc_pix_out_if and the cipher RTL.
module testbench;

  localparam int unsigned HALF_PERIOD      = 6;
  localparam int unsigned RESET_CYCLES     = 7;
  localparam int unsigned RANDOM_PHASES    = 12;
  localparam int unsigned PHASE_ITEMS      = 100;
  localparam int unsigned LONG_SKIP        = 20000;
  localparam int unsigned DRAIN_CYCLES     = 4;
  localparam int unsigned WATCHDOG_LIMIT   = 100000;
  localparam logic [xcc_pkg::CFG_IDX_W-1:0] REG_INDEX_UNUSED = 8'hC3;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_BURSTY
  } rx_mode_e;

  class pixel_cipher_scoreboard;
    logic [31:0] seed_q;
    logic [31:0] start_q;
    logic [23:0] skip_q;
    logic        decrypt_q;
    logic [31:0] keystream;
    logic [23:0] chain;
    logic [23:0] expected_pixels[$];
    int unsigned failures;

    function new();
      seed_q    = xcc_pkg::RESET_SEED;
      start_q   = '0;
      skip_q    = '0;
      decrypt_q = 1'b0;
      keystream = xcc_pkg::RESET_SEED;
      chain     = '0;
      failures  = 0;
    endfunction

    function logic [31:0] xorshift(input logic [31:0] x);
      logic [31:0] y;
      y = x ^ (x << 13);
      y = y ^ (y >> 17);
      y = y ^ (y << 5);
      return y;
    endfunction

    function void write_reg(input logic [xcc_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
      case (idx)
        xcc_pkg::REG_SEED:         seed_q    = data;
        xcc_pkg::REG_START_VALUE:  start_q   = data;
        xcc_pkg::REG_SKIP_COUNT:   skip_q    = data[23:0];
        xcc_pkg::REG_DECRYPT_MODE: decrypt_q = data[0];
        default: ;
      endcase
    endfunction

    function void note_pixel(input logic [23:0] pix, input logic first);
      logic [23:0] res;
      int unsigned n;
      if (first) begin
        keystream = seed_q;
        for (n = 0; n < skip_q; n++) keystream = xorshift(keystream);
        chain = start_q[23:0];
      end
      keystream = xorshift(keystream);
      res = pix ^ chain ^ keystream[23:0];
      chain = decrypt_q ? pix : res;
      expected_pixels.push_back(res);
    endfunction

    function void check_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
      logic [23:0] want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: blue %0h green %0h red %0h", b, g, r);
        failures++;
        return;
      end
      want = expected_pixels.pop_front();
      if (b !== want[7:0]) begin
        $error("blue_out: expected %0h, actual %0h", want[7:0], b);
        failures++;
      end
      if (g !== want[15:8]) begin
        $error("green_out: expected %0h, actual %0h", want[15:8], g);
        failures++;
      end
      if (r !== want[23:16]) begin
        $error("red_out: expected %0h, actual %0h", want[23:16], r);
        failures++;
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we;
  logic [xcc_pkg::CFG_IDX_W-1:0]   cfg_idx;
  logic [xcc_pkg::CFG_DATA_W-1:0]  cfg_data;

  xcc_pix_in_if  pix_in ();
  xcc_pix_out_if pix_out ();

  pixel_cipher_scoreboard sb;

  rx_mode_e    rx_mode    = RX_ALWAYS;
  int unsigned rx_left    = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned image_left = 0;

  xorshift_chained_xor_pixel_cipher i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (pix_in),
    .out_o      (pix_out)
  );

  always begin
    clk_i = 1'b0;
    #HALF_PERIOD;
    clk_i = 1'b1;
    #HALF_PERIOD;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pix_in.valid && pix_in.ready) begin
        sb.note_pixel({pix_in.red_in, pix_in.green_in, pix_in.blue_in}, pix_in.first_pixel);
      end
      if (pix_out.valid && pix_out.ready) begin
        sb.check_pixel(pix_out.blue_out, pix_out.green_out, pix_out.red_out);
      end
    end
  end

  // Receiver stall pattern: switch between always ready, coin toss and long stalls.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_e'($urandom_range(0, 2));
        rx_left <= $urandom_range(32, 256);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_ALWAYS: pix_out.ready <= 1'b1;
        RX_COIN:   pix_out.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_left != 0) begin
            pix_out.ready <= 1'b0;
            stall_left    <= stall_left - 1;
          end else if ($urandom_range(0, 7) == 0) begin
            pix_out.ready <= 1'b0;
            stall_left    <= $urandom_range(1, 20);
          end else begin
            pix_out.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [23:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_pixel(input logic [23:0] pix, input logic first);
    @(negedge clk_i);
    pix_in.valid       <= 1'b1;
    pix_in.blue_in     <= pix[7:0];
    pix_in.green_in    <= pix[15:8];
    pix_in.red_in      <= pix[23:16];
    pix_in.first_pixel <= first;
    do @(posedge clk_i); while (!pix_in.ready);
  endtask

  task automatic pause_sender(input int unsigned n);
    if (n != 0) begin
      @(negedge clk_i);
      pix_in.valid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    pause_sender(1);
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [xcc_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    logic        first;
    sent = 0;
    image_left = 0;
    // Occasionally open with pixels that carry on from the previous image.
    if ($urandom_range(0, 3) == 0) image_left = $urandom_range(1, 5);
    else image_left = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 24);
      while (burst != 0 && sent < n_items) begin
        if (image_left == 0) begin
          first      = 1'b1;
          image_left = $urandom_range(1, 48);
        end else begin
          first      = ($urandom_range(0, 39) == 0);
          image_left = image_left - 1;
        end
        send_pixel(rand_pixel(), first);
        sent++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
    end
  endtask

  initial begin
    int unsigned phase;
    sb = new();
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_data           = '0;
    pix_in.valid       = 1'b0;
    pix_in.blue_in     = '0;
    pix_in.green_in    = '0;
    pix_in.red_in      = '0;
    pix_in.first_pixel = 1'b0;
    pix_out.ready      = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Pixels ahead of any first pixel run on the reset generator and a zero chain.
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'hFF0000, 1'b0);
    send_pixel(24'h00FF00, 1'b0);
    send_pixel(24'h0000FF, 1'b0);
    send_pixel(rand_pixel(), 1'b0);
    drain();

    // Writes hold off until the next first pixel; the unused index is dropped.
    write_reg(xcc_pkg::REG_SEED, 32'hFFFF_FFFF);
    write_reg(xcc_pkg::REG_START_VALUE, 32'hFFFF_FFFF);
    write_reg(xcc_pkg::REG_SKIP_COUNT, 32'h0000_0000);
    write_reg(xcc_pkg::REG_DECRYPT_MODE, 32'h0000_0000);
    write_reg(REG_INDEX_UNUSED, 32'hFFFF_FFFF);
    end_writes();
    send_pixel(24'h123456, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h000000, 1'b0);
    send_pixel(rand_pixel(), 1'b0);
    send_pixel(rand_pixel(), 1'b0);
    send_pixel(24'hFFFFFF, 1'b1);
    drain();

    // Zero seed leaves only the chaining, here on the inputs.
    write_reg(xcc_pkg::REG_SEED, 32'h0000_0000);
    write_reg(xcc_pkg::REG_START_VALUE, 32'h0000_0000);
    write_reg(xcc_pkg::REG_SKIP_COUNT, 32'hFF00_0003);
    write_reg(xcc_pkg::REG_DECRYPT_MODE, 32'hFFFF_FFFF);
    end_writes();
    send_pixel(24'hFFFFFF, 1'b1);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'hA5A5A5, 1'b0);
    send_pixel(24'h5A5A5A, 1'b0);
    drain();

    // Largest skip stays pending; a long skip is then run on one first pixel.
    write_reg(xcc_pkg::REG_SEED, $urandom);
    write_reg(xcc_pkg::REG_SKIP_COUNT, 32'h00FF_FFFF);
    write_reg(xcc_pkg::REG_DECRYPT_MODE, 32'h0000_0000);
    end_writes();
    send_pixel(rand_pixel(), 1'b0);
    send_pixel(rand_pixel(), 1'b0);
    send_pixel(rand_pixel(), 1'b0);
    drain();
    write_reg(xcc_pkg::REG_SKIP_COUNT, LONG_SKIP);
    write_reg(xcc_pkg::REG_START_VALUE, $urandom);
    end_writes();
    send_pixel(rand_pixel(), 1'b1);
    send_pixel(rand_pixel(), 1'b0);
    send_pixel(rand_pixel(), 1'b0);
    drain();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_reg(xcc_pkg::REG_SEED, rand_word());
      write_reg(xcc_pkg::REG_START_VALUE, rand_word());
      if ($urandom_range(0, 9) == 0) write_reg(xcc_pkg::REG_SKIP_COUNT, $urandom_range(16, 300));
      else write_reg(xcc_pkg::REG_SKIP_COUNT, $urandom_range(0, 15));
      write_reg(xcc_pkg::REG_DECRYPT_MODE, $urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) write_reg(REG_INDEX_UNUSED, $urandom);
      end_writes();
      random_phase(PHASE_ITEMS);
      drain();
    end

    repeat (2 * DRAIN_CYCLES) @(posedge clk_i);
    if (sb.expected_pixels.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_pixels.size());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
